[design/ax25ufb_pkg.sv]
// Package for the AX.25 UI frame builder: shared types, register indexes,
// sequencer states, header constants and the FCS step function.
// No dependencies.
`default_nettype none

package ax25ufb_pkg;

  localparam int unsigned MaxOpenFlagsDef = 32;
  localparam int unsigned CfgIndexW       = 3;
  localparam int unsigned CfgDataW        = 48;
  localparam int unsigned AddrLen         = 21;

  localparam logic [7:0]  FlagByte   = 8'h7E;
  localparam logic [7:0]  DestSsidHi = 8'h70;
  localparam logic [7:0]  SrcSsidHi  = 8'h30;
  localparam logic [7:0]  PathEnd    = 8'h31;
  localparam logic [7:0]  CtrlUi     = 8'h03;
  localparam logic [7:0]  PidNone    = 8'hF0;
  localparam logic [15:0] FcsInit    = 16'hFFFF;

  localparam logic [7:0] DestText [6] = '{8'h41, 8'h50, 8'h52, 8'h53, 8'h20, 8'h20};

  typedef enum logic [CfgIndexW-1:0] {
    REG_OPEN_FLAGS = 3'd0,
    REG_SRC_CALL   = 3'd1,
    REG_SRC_SSID   = 3'd2,
    REG_DEST_SSID  = 3'd3,
    REG_PATH_CALL  = 3'd4
  } reg_index_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FLAGS,
    ST_ADDR,
    ST_CTRL,
    ST_PID,
    ST_PAYLOAD,
    ST_FCS_LO,
    ST_FCS_HI,
    ST_CLOSE
  } seq_state_e;

  typedef struct packed {
    logic [5:0]  open_flags;
    logic [47:0] src_call;
    logic [3:0]  src_ssid;
    logic [3:0]  dest_ssid;
    logic [47:0] path_call;
  } cfg_t;

  // One classified request: first marks the byte that opens a frame.
  typedef struct packed {
    logic       first;
    logic       last;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       run_last;
  } out_t;

  function automatic logic [7:0] call_byte(input logic [47:0] word, input logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = word[47:40];
      3'd1:    b = word[39:32];
      3'd2:    b = word[31:24];
      3'd3:    b = word[23:16];
      3'd4:    b = word[15:8];
      3'd5:    b = word[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // Address field byte at position idx, already shifted into AX.25 form.
  function automatic logic [7:0] addr_byte(input logic [4:0] idx, input cfg_t cfg);
    logic [7:0] raw;
    logic       ext;
    ext = (idx == 5'(AddrLen - 1));
    if (idx < 5'd6) begin
      raw = DestText[idx[2:0]];
    end else if (idx == 5'd6) begin
      raw = DestSsidHi | {4'h0, cfg.dest_ssid};
    end else if (idx < 5'd13) begin
      raw = call_byte(cfg.src_call, 3'(idx - 5'd7));
    end else if (idx == 5'd13) begin
      raw = SrcSsidHi | {4'h0, cfg.src_ssid};
    end else if (idx < 5'd20) begin
      raw = call_byte(cfg.path_call, 3'(idx - 5'd14));
    end else begin
      raw = PathEnd;
    end
    return {raw[6:0], ext};
  endfunction

  // Reflected CRC-16-CCITT, one byte.
  function automatic logic [15:0] fcs_step(input logic [15:0] acc, input logic [7:0] b);
    logic [7:0] t;
    t = b ^ acc[7:0];
    t = t ^ {t[3:0], 4'h0};
    return {t, acc[15:8]} ^ {12'h000, t[7:4]} ^ {5'b00000, t, 3'b000};
  endfunction

endpackage

`default_nettype wire

[design/ax25ufb_fifo.sv]
// Two-entry queue used between front and back and in front of the result port.
// Depends on nothing; the caller pushes only when not full or popping.
`default_nettype none

module ax25ufb_fifo #(
  parameter int unsigned DataW = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [DataW-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [DataW-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  logic [DataW-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             do_pop;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (do_pop) rd_ptr_q <= !rd_ptr_q;
      if (push_i && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[design/ax25ufb_front.sv]
// Front end: accepts payload bytes and tags the one that opens a frame.
// Depends on ax25ufb_pkg.
`default_nettype none

module ax25ufb_front
  import ax25ufb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire logic [7:0] payload_byte_i,
  input  wire logic       payload_last_i,
  input  wire logic       cmd_full_i,
  output logic            full_o,
  output logic            cmd_push_o,
  output cmd_t            cmd_o
);

  logic frame_open_q, frame_open_d;

  assign full_o     = cmd_full_i;
  assign cmd_push_o = push_i && !cmd_full_i;

  always_comb begin
    cmd_o.first = !frame_open_q;
    cmd_o.last  = payload_last_i;
    cmd_o.data  = payload_byte_i;
    frame_open_d = frame_open_q;
    if (cmd_push_o) begin
      frame_open_d = !payload_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

`default_nettype wire

[design/ax25ufb_back.sv]
// Back end: sequencer that streams flags, address, control, PID, payload,
// FCS and closing flags, and keeps the running FCS. Depends on ax25ufb_pkg.
`default_nettype none

module ax25ufb_back
  import ax25ufb_pkg::*;
#(
  parameter int unsigned MAX_OPEN_FLAGS = MaxOpenFlagsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire cfg_t cfg_i,
  input  wire logic cmd_valid_i,
  input  wire cmd_t cmd_i,
  output logic      cmd_pop_o,
  input  wire logic out_rdy_i,
  output logic      out_push_o,
  output out_t      out_o
);

  localparam int unsigned FlagCntW = $clog2(MAX_OPEN_FLAGS + 1);

  seq_state_e           state_q, state_d;
  logic [FlagCntW-1:0]  flag_cnt_q, flag_cnt_d, flag_load;
  logic [4:0]           idx_q, idx_d;
  logic [15:0]          crc_q, crc_d;
  logic                 emit, crc_upd, start_hdr;

  always_comb begin
    if (cfg_i.open_flags > 6'(MAX_OPEN_FLAGS)) begin
      flag_load = FlagCntW'(MAX_OPEN_FLAGS);
    end else begin
      flag_load = FlagCntW'(cfg_i.open_flags);
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.first) begin
          state_d = (flag_load != '0) ? ST_FLAGS : ST_ADDR;
        end else if (cmd_valid_i && out_rdy_i && cmd_i.last) begin
          state_d = ST_FCS_LO;
        end
      end
      ST_FLAGS:   if (out_rdy_i && flag_cnt_q == FlagCntW'(1)) state_d = ST_ADDR;
      ST_ADDR:    if (out_rdy_i && idx_q == 5'(AddrLen - 1)) state_d = ST_CTRL;
      ST_CTRL:    if (out_rdy_i) state_d = ST_PID;
      ST_PID:     if (out_rdy_i) state_d = ST_PAYLOAD;
      ST_PAYLOAD: if (out_rdy_i) state_d = cmd_i.last ? ST_FCS_LO : ST_IDLE;
      ST_FCS_LO:  if (out_rdy_i) state_d = ST_FCS_HI;
      ST_FCS_HI:  if (out_rdy_i) state_d = ST_CLOSE;
      ST_CLOSE:   if (out_rdy_i && idx_q == 5'd2) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    emit            = 1'b0;
    crc_upd         = 1'b0;
    start_hdr       = 1'b0;
    cmd_pop_o       = 1'b0;
    out_o.data      = FlagByte;
    out_o.frame_end = 1'b0;
    out_o.run_last  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i && cmd_i.first) begin
          start_hdr = 1'b1;
        end else if (cmd_valid_i) begin
          emit           = 1'b1;
          crc_upd        = 1'b1;
          out_o.data     = cmd_i.data;
          out_o.run_last = !cmd_i.last;
          cmd_pop_o      = out_rdy_i && !cmd_i.last;
        end
      end
      ST_FLAGS: emit = 1'b1;
      ST_ADDR: begin
        emit       = 1'b1;
        crc_upd    = 1'b1;
        out_o.data = addr_byte(idx_q, cfg_i);
      end
      ST_CTRL: begin
        emit       = 1'b1;
        crc_upd    = 1'b1;
        out_o.data = CtrlUi;
      end
      ST_PID: begin
        emit       = 1'b1;
        crc_upd    = 1'b1;
        out_o.data = PidNone;
      end
      ST_PAYLOAD: begin
        emit           = 1'b1;
        crc_upd        = 1'b1;
        out_o.data     = cmd_i.data;
        out_o.run_last = !cmd_i.last;
        cmd_pop_o      = out_rdy_i && !cmd_i.last;
      end
      ST_FCS_LO: begin
        emit       = 1'b1;
        out_o.data = ~crc_q[7:0];
      end
      ST_FCS_HI: begin
        emit       = 1'b1;
        out_o.data = ~crc_q[15:8];
      end
      ST_CLOSE: begin
        emit            = 1'b1;
        out_o.frame_end = (idx_q == 5'd2);
        out_o.run_last  = (idx_q == 5'd2);
        cmd_pop_o       = out_rdy_i && (idx_q == 5'd2);
      end
      default: emit = 1'b0;
    endcase
    out_push_o = emit && out_rdy_i;
  end

  // Counters and FCS.
  always_comb begin
    flag_cnt_d = flag_cnt_q;
    idx_d      = idx_q;
    crc_d      = crc_q;
    if (start_hdr) begin
      flag_cnt_d = flag_load;
      crc_d      = FcsInit;
    end
    if (out_push_o) begin
      if (crc_upd) crc_d = fcs_step(crc_q, out_o.data);
      if (state_q == ST_FLAGS) flag_cnt_d = flag_cnt_q - FlagCntW'(1);
      if (state_q == ST_ADDR || state_q == ST_CLOSE) begin
        idx_d = (state_d == state_q) ? idx_q + 5'd1 : 5'd0;
      end
      if (out_o.frame_end) crc_d = FcsInit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      flag_cnt_q <= '0;
      idx_q      <= 5'd0;
      crc_q      <= FcsInit;
    end else begin
      state_q    <= state_d;
      flag_cnt_q <= flag_cnt_d;
      idx_q      <= idx_d;
      crc_q      <= crc_d;
    end
  end

endmodule

`default_nettype wire

[design/ax25_ui_frame_builder.sv]
// AX.25 UI frame builder: top level with configuration registers, front end,
// request queue, sequencer and result queue.
// Depends on ax25ufb_pkg, ax25ufb_front, ax25ufb_fifo, ax25ufb_back.
//
// Usage:
//   Input is a queue-style channel: a payload byte is taken on a clock edge
//   with push_i high and full_o low. payload_last_i closes the frame.
//   Results leave through a queue-style channel: while empty_o is low the
//   oldest byte is on frame_byte_o / frame_end_o / run_last_o, and pop_i
//   takes it. run_last_o flags the last byte caused by one payload byte.
//   Configuration goes through cfg_valid_i / cfg_ready_o (always ready) with
//   cfg_index_i selecting the register; write only while the block is idle.
// Timing:
//   A two-entry request queue parts the front from the sequencer, and a
//   two-entry result queue parts the sequencer from the output. The first
//   byte of a frame brings a setup step, then the open flags (saturated at
//   MAX_OPEN_FLAGS), 21 address bytes, control, PID and the payload byte.
//   Following payload bytes stream at one per cycle while the result queue
//   has room; the sequencer, one byte per cycle, sets the rate. The last
//   byte adds two FCS bytes and three closing flags. A result passes the
//   request and result queues; a frame opener also waits for setup and header.
// Reset:
//   Registers return to their reset values, the FCS to 0xFFFF, no frame is
//   open and both queues drain. When pop_i stays low the result queue fills,
//   the sequencer holds, then the request queue fills and full_o rises.
`default_nettype none

module ax25_ui_frame_builder
  import ax25ufb_pkg::*;
#(
  parameter int unsigned MAX_OPEN_FLAGS = MaxOpenFlagsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  output logic                      full_o,
  input  wire logic [7:0]           payload_byte_i,
  input  wire logic                 payload_last_i,
  output logic                      empty_o,
  input  wire logic                 pop_i,
  output logic      [7:0]           frame_byte_o,
  output logic                      frame_end_o,
  output logic                      run_last_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIndexW-1:0] cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  cfg_t cfg_q;
  cmd_t front_cmd, queue_cmd;
  out_t back_out, queue_out;
  logic cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic out_push, out_full, out_rdy;

  // Configuration registers; unknown indexes drop the write.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_flags <= 6'd16;
      cfg_q.src_call   <= 48'h0;
      cfg_q.src_ssid   <= 4'd11;
      cfg_q.dest_ssid  <= 4'd0;
      cfg_q.path_call  <= 48'h0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OPEN_FLAGS: cfg_q.open_flags <= cfg_data_i[5:0];
        REG_SRC_CALL:   cfg_q.src_call   <= cfg_data_i[47:0];
        REG_SRC_SSID:   cfg_q.src_ssid   <= cfg_data_i[3:0];
        REG_DEST_SSID:  cfg_q.dest_ssid  <= cfg_data_i[3:0];
        REG_PATH_CALL:  cfg_q.path_call  <= cfg_data_i[47:0];
        default:        cfg_q            <= cfg_q;
      endcase
    end
  end

  ax25ufb_front u_front (
    .clk_i,
    .rst_ni,
    .push_i,
    .payload_byte_i,
    .payload_last_i,
    .cmd_full_i (cmd_full),
    .full_o,
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd)
  );

  ax25ufb_fifo #(
    .DataW ($bits(cmd_t))
  ) u_cmd_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .pop_i   (cmd_pop),
    .data_o  (queue_cmd),
    .full_o  (cmd_full),
    .empty_o (cmd_empty)
  );

  // Advance the sequencer when the result queue has room or is being popped.
  assign out_rdy = !out_full || pop_i;

  ax25ufb_back #(
    .MAX_OPEN_FLAGS (MAX_OPEN_FLAGS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (queue_cmd),
    .cmd_pop_o   (cmd_pop),
    .out_rdy_i   (out_rdy),
    .out_push_o  (out_push),
    .out_o       (back_out)
  );

  ax25ufb_fifo #(
    .DataW ($bits(out_t))
  ) u_out_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (out_push),
    .data_i  (back_out),
    .pop_i,
    .data_o  (queue_out),
    .full_o  (out_full),
    .empty_o
  );

  assign frame_byte_o = queue_out.data;
  assign frame_end_o  = queue_out.frame_end;
  assign run_last_o   = queue_out.run_last;

  // A closing flag always finishes the request that caused it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && frame_end_o |-> run_last_o)
    else $error("frame end without run end");

  // The result queue never takes a byte it has no room for.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> !out_full || pop_i)
    else $error("result queue overflow");

  // The sequencer only releases a request that is present, with the pushed byte that ends its run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> !cmd_empty && out_push && back_out.run_last)
    else $error("request released without its last byte");

endmodule

`default_nettype wire

[dv/ax25_ui_frame_builder_tb.sv]
// Testbench for ax25_ui_frame_builder: directed and random payload streams
// checked byte for byte against a predictor with its own register shadow and FCS.
// Depends on ax25ufb_pkg and the ax25_ui_frame_builder RTL.
`default_nettype none

module ax25_ui_frame_builder_tb;
  import ax25ufb_pkg::*;

  // Flags past this count saturate in the header.
  localparam int unsigned MaxFlags = MaxOpenFlagsDef;
  // Destination callsign, first character in the top byte.
  localparam logic [47:0] DestCall = "APRS  ";
  // Reflected CCITT polynomial, used bit by bit in the FCS predictor.
  localparam logic [15:0] FcsPoly = 16'h8408;
  // Indexes from here up select no register.
  localparam int unsigned FirstUnusedIdx = int'(REG_PATH_CALL) + 1;
  // Cycles to let the two queues and the sequencer settle before a write.
  localparam int unsigned SettleCycles = 12;
  // Cycles with work pending and no request moving before the run is abandoned.
  localparam int unsigned StallLimit = 4000;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int unsigned MaxPrinted = 100;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 push_i         = 1'b0;
  logic [7:0]           payload_byte_i = 8'h00;
  logic                 payload_last_i = 1'b0;
  logic                 pop_i          = 1'b0;
  logic                 cfg_valid_i    = 1'b0;
  logic [CfgIndexW-1:0] cfg_index_i    = '0;
  logic [CfgDataW-1:0]  cfg_data_i     = '0;
  logic                 full_o;
  logic                 empty_o;
  logic [7:0]           frame_byte_o;
  logic                 frame_end_o;
  logic                 run_last_o;
  logic                 cfg_ready_o;

  // Predictor state: register shadow, running FCS and the open-frame flag.
  cfg_t        cfg_shadow;
  logic [15:0] fcs_acc;
  logic        frame_is_open;

  // Frame bytes still owed by the block, oldest first.
  out_t        frame_bytes_q[$];

  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned pop_idle_pct   = 0;
  int unsigned stall_cycles   = 0;

  ax25_ui_frame_builder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .payload_byte_i (payload_byte_i),
    .payload_last_i (payload_last_i),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .frame_byte_o   (frame_byte_o),
    .frame_end_o    (frame_end_o),
    .run_last_o     (run_last_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #1 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Advance the reflected CRC-16-CCITT by one byte, LSB first.
  function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
    for (int i = 0; i < 8; i++) begin
      if (acc[0] ^ b[i]) begin
        acc = (acc >> 1) ^ FcsPoly;
      end else begin
        acc = acc >> 1;
      end
    end
    return acc;
  endfunction

  task automatic owe_byte(input logic [7:0] b, input logic is_end);
    frame_bytes_q.push_back('{data: b, frame_end: is_end, run_last: 1'b0});
  endtask

  // Owe a byte that the FCS covers.
  task automatic owe_fcs_byte(input logic [7:0] b);
    fcs_acc = fcs_update(fcs_acc, b);
    owe_byte(b, 1'b0);
  endtask

  // Work out every frame byte that one accepted payload request causes.
  task automatic predict_frame_bytes(input logic [7:0] pb, input logic last);
    logic [167:0] addr_field;
    logic [7:0]   ab;
    logic [15:0]  fcs;
    int unsigned  n_flags;
    out_t         tail;
    if (!frame_is_open) begin
      n_flags = (cfg_shadow.open_flags > MaxFlags) ? MaxFlags : cfg_shadow.open_flags;
      repeat (n_flags) owe_byte(FlagByte, 1'b0);
      addr_field = {DestCall, DestSsidHi | {4'h0, cfg_shadow.dest_ssid}, cfg_shadow.src_call,
                    SrcSsidHi | {4'h0, cfg_shadow.src_ssid}, cfg_shadow.path_call, PathEnd};
      fcs_acc = FcsInit;
      // Shift each address byte up by one; only the final one carries the end bit.
      for (int i = 0; i < AddrLen; i++) begin
        ab = addr_field[167 - 8 * i -: 8] << 1;
        if (i == AddrLen - 1) ab[0] = 1'b1;
        owe_fcs_byte(ab);
      end
      owe_fcs_byte(CtrlUi);
      owe_fcs_byte(PidNone);
      frame_is_open = 1'b1;
    end
    owe_fcs_byte(pb);
    if (last) begin
      fcs = ~fcs_acc;
      owe_byte(fcs[7:0], 1'b0);
      owe_byte(fcs[15:8], 1'b0);
      owe_byte(FlagByte, 1'b0);
      owe_byte(FlagByte, 1'b0);
      owe_byte(FlagByte, 1'b1);
      fcs_acc = FcsInit;
      frame_is_open = 1'b0;
    end
    // Mark the final byte of this request's run.
    tail = frame_bytes_q.pop_back();
    tail.run_last = 1'b1;
    frame_bytes_q.push_back(tail);
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Offer one payload request, idling first at the sender's rate. Push is left
  // high on return so that a following request can go out back to back; the
  // caller drops it through wait_drained.
  task automatic send_payload(input logic [7:0] pb, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push_i <= 1'b0;
      @(posedge clk_i);
    end
    push_i         <= 1'b1;
    payload_byte_i <= pb;
    payload_last_i <= last;
    do @(posedge clk_i); while (full_o);
    predict_frame_bytes(pb, last);
  endtask

  // Drop push, wait for every owed byte to leave, then let the pipeline settle.
  task automatic wait_drained();
    push_i <= 1'b0;
    while (frame_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register; the caller makes sure the block is idle.
  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_OPEN_FLAGS: cfg_shadow.open_flags = val[5:0];
      REG_SRC_CALL:   cfg_shadow.src_call   = val[47:0];
      REG_SRC_SSID:   cfg_shadow.src_ssid   = val[3:0];
      REG_DEST_SSID:  cfg_shadow.dest_ssid  = val[3:0];
      REG_PATH_CALL:  cfg_shadow.path_call  = val[47:0];
      default:        ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic [CfgDataW-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Open flag count with random junk above bit 5, which the block must mask.
  function automatic logic [CfgDataW-1:0] flag_word(input int unsigned n);
    logic [CfgDataW-1:0] w;
    w      = rand_word();
    w[5:0] = n[5:0];
    return w;
  endfunction

  task automatic set_idling(input int unsigned send_pct, input int unsigned pop_pct);
    send_idle_pct = send_pct;
    pop_idle_pct  = pop_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random pop, field-by-field check, stall watchdog
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (mismatch_count < MaxPrinted) begin
      $display("MISMATCH at %0t: %s got %02h expected %02h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(0, 99) >= pop_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_frame_bytes
    out_t want;
    if (rst_ni && pop_i && !empty_o) begin
      if (frame_bytes_q.size() == 0) begin
        report_mismatch("frame byte with none owed", frame_byte_o, 8'h00);
      end else begin
        want = frame_bytes_q.pop_front();
        if (frame_byte_o !== want.data) begin
          report_mismatch("frame_byte", frame_byte_o, want.data);
        end
        if (frame_end_o !== want.frame_end) begin
          report_mismatch("frame_end", {7'h00, frame_end_o}, {7'h00, want.frame_end});
        end
        if (run_last_o !== want.run_last) begin
          report_mismatch("run_last", {7'h00, run_last_o}, {7'h00, want.run_last});
        end
      end
    end
  end

  // Count cycles in which work is pending but no request moves on any channel.
  always @(posedge clk_i) begin
    if ((push_i && !full_o) || (pop_i && !empty_o) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (push_i || cfg_valid_i || frame_bytes_q.size() != 0) begin
      if (stall_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end else begin
      stall_cycles <= 0;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset register values; a zero payload byte passes through without ending the frame.
  task automatic test_reset_header();
    send_payload(8'h00, 1'b0);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h5A, 1'b1);
    wait_drained();
  endtask

  // Longest run: full flag count and all-ones fields, header to trailer from one request.
  task automatic test_single_byte_frames();
    write_reg(REG_OPEN_FLAGS, flag_word(MaxFlags));
    write_reg(REG_SRC_CALL, {CfgDataW{1'b1}});
    write_reg(REG_SRC_SSID, {CfgDataW{1'b1}});
    write_reg(REG_DEST_SSID, {CfgDataW{1'b1}});
    write_reg(REG_PATH_CALL, {CfgDataW{1'b1}});
    send_payload(8'h80, 1'b1);
    send_payload(8'h01, 1'b1);
    wait_drained();
  endtask

  // No flags, one flag, and counts above the maximum that must saturate.
  task automatic test_open_flag_counts();
    int unsigned counts[4];
    counts = '{0, 1, MaxFlags + 1, 63};
    foreach (counts[i]) begin
      write_reg(REG_OPEN_FLAGS, flag_word(counts[i]));
      send_payload(8'($urandom_range(0, 255)), 1'b1);
      wait_drained();
    end
  endtask

  // All-zero address fields, ignored indexes, and a write while a frame is open.
  task automatic test_address_fields();
    write_reg(REG_OPEN_FLAGS, flag_word(2));
    write_reg(REG_SRC_CALL, '0);
    write_reg(REG_SRC_SSID, '0);
    write_reg(REG_DEST_SSID, '0);
    write_reg(REG_PATH_CALL, '0);
    send_payload(8'h3C, 1'b0);
    send_payload(8'hC3, 1'b1);
    wait_drained();
    for (int k = FirstUnusedIdx; k < (1 << CfgIndexW); k++) begin
      write_reg(CfgIndexW'(k), {CfgDataW{1'b1}});
    end
    send_payload(8'h42, 1'b1);
    wait_drained();
    // The new values must only show in the next header, not in this frame's FCS.
    send_payload(8'h11, 1'b0);
    wait_drained();
    write_reg(REG_SRC_SSID, 48'h5);
    write_reg(REG_SRC_CALL, rand_word());
    send_payload(8'h22, 1'b1);
    send_payload(8'h33, 1'b1);
    wait_drained();
  endtask

  // Alternating bit patterns, the flag value itself and the byte extremes.
  task automatic test_payload_bits();
    logic [7:0] pattern[6];
    pattern = '{8'h55, 8'hAA, 8'h7E, 8'h00, 8'hFF, 8'h01};
    foreach (pattern[i]) send_payload(pattern[i], i == 5);
    wait_drained();
  endtask

  // Write a random subset of registers; flag counts stay small most of the time.
  task automatic shuffle_config();
    if ($urandom_range(0, 1)) begin
      write_reg(REG_OPEN_FLAGS, flag_word(($urandom_range(0, 9) == 0) ?
                                          $urandom_range(MaxFlags, 63) :
                                          $urandom_range(0, 6)));
    end
    if ($urandom_range(0, 1)) write_reg(REG_SRC_CALL, rand_word());
    if ($urandom_range(0, 1)) write_reg(REG_SRC_SSID, rand_word());
    if ($urandom_range(0, 1)) write_reg(REG_DEST_SSID, rand_word());
    if ($urandom_range(0, 1)) write_reg(REG_PATH_CALL, rand_word());
    if ($urandom_range(0, 7) == 0) write_reg(CfgIndexW'($urandom_range(FirstUnusedIdx,
                                                       (1 << CfgIndexW) - 1)), rand_word());
  endtask

  // Random frames with random contents; the config moves between frames and,
  // now and then, while a frame is still open.
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_drained();
        shuffle_config();
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (i != 0 && $urandom_range(0, 29) == 0) begin
          wait_drained();
          shuffle_config();
        end
        send_payload(8'($urandom_range(0, 255)), i == len - 1);
        sent++;
      end
    end
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    cfg_shadow = '{open_flags: 6'd16, src_call: 48'h0, src_ssid: 4'd11,
                   dest_ssid: 4'd0, path_call: 48'h0};
    fcs_acc       = FcsInit;
    frame_is_open = 1'b0;

    // Hold reset, then release it on a clock edge.
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Sender idles a little, receiver a lot: the result side backs up.
    set_idling(10, 68);
    test_reset_header();
    test_single_byte_frames();
    test_open_flag_counts();
    test_address_fields();
    test_payload_bits();
    test_random_frames(115);

    // Sender idles a lot, receiver a little: the block runs dry between requests.
    set_idling(68, 10);
    test_random_frames(115);

    // Neither side idles: full rate through both queues.
    set_idling(0, 0);
    test_random_frames(115);

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
